FILE: hdl/xor_basis_kth_smallest_unit_assert.svh
// ----------------------------------------------------------------------------
// xor basis unit assertion macros
// concurrent checks used by the sequencer rtl (xbk_seq)
// ----------------------------------------------------------------------------
`ifndef XOR_BASIS_KTH_SMALLEST_UNIT_ASSERT_SVH
`define XOR_BASIS_KTH_SMALLEST_UNIT_ASSERT_SVH

// same-cycle implication
`define XBK_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XBK_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/xbk_pkg.sv
// ----------------------------------------------------------------------------
// xbk_pkg
// types and constants shared by the xor basis unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xbk_pkg;

  localparam int unsigned XBK_VALUE_BITS = 63;
  localparam int unsigned XBK_FIELD_BITS = 63;
  localparam int unsigned XBK_RANK_BITS  = 6;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2
  } xbk_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ELIM,
    ST_PUT,
    ST_QUERY,
    ST_DONE
  } xbk_state_e;

  typedef struct packed {
    logic [1:0]                kind;
    logic [XBK_FIELD_BITS-1:0] insert_value;
    logic [XBK_FIELD_BITS-1:0] query_rank;
  } xbk_in_t;

  typedef struct packed {
    logic [XBK_FIELD_BITS-1:0] result_value;
    logic                      no_such_rank;
    logic [XBK_RANK_BITS-1:0]  basis_rank;
  } xbk_out_t;

endpackage

`default_nettype wire

FILE: hdl/xbk_row_ram.sv
// ----------------------------------------------------------------------------
// xbk_row_ram
// basis row storage, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xbk_row_ram #(
  parameter int unsigned DEPTH = 63,
  parameter int unsigned WIDTH = 63
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/xbk_seq.sv
// ----------------------------------------------------------------------------
// xbk_seq
// row sequencer: reduction scan, elimination, insert and query walks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "xor_basis_kth_smallest_unit_assert.svh"

module xbk_seq #(
  parameter int unsigned VALUE_BITS = xbk_pkg::XBK_VALUE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  xbk_pkg::xbk_in_t              item_i,
  output logic                          idle_o,
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output xbk_pkg::xbk_out_t             res_o,
  output logic                          mem_re_o,
  output logic [$clog2(VALUE_BITS)-1:0] mem_raddr_o,
  input  logic [VALUE_BITS-1:0]         mem_rdata_i,
  output logic                          mem_we_o,
  output logic [$clog2(VALUE_BITS)-1:0] mem_waddr_o,
  output logic [VALUE_BITS-1:0]         mem_wdata_o
);

  import xbk_pkg::*;

  localparam int unsigned AW = $clog2(VALUE_BITS);
  localparam logic [AW-1:0] LAST_ROW = AW'(VALUE_BITS - 1);

  xbk_state_e state_q, state_d;
  logic [1:0] kind_q, kind_d;
  logic [VALUE_BITS-1:0] t_q, t_d;
  logic [VALUE_BITS-1:0] k_q, k_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [AW-1:0] pivot_q, pivot_d;
  logic issue_q, issue_d;
  logic rd_pend_q, rd_pend_d;
  logic piv_found_q, piv_found_d;
  logic [VALUE_BITS-1:0] valid_q, valid_d;
  logic [XBK_RANK_BITS-1:0] rank_q, rank_d;
  logic zero_q, zero_d;
  logic miss_q, miss_d;

  logic [XBK_FIELD_BITS-1:0] k_adj;
  logic [XBK_FIELD_BITS-1:0] hi_mask;
  logic [XBK_FIELD_BITS-1:0] acc_ext;
  logic rd_bit;
  logic row_ok;

  // bits at or above the current rank; any of them set means no such rank
  always_comb begin
    for (int b = 0; b < XBK_FIELD_BITS; b++) begin
      hi_mask[b] = (XBK_RANK_BITS'(b) >= rank_q);
    end
  end

  assign k_adj  = item_i.query_rank - XBK_FIELD_BITS'(zero_q);
  assign rd_bit = t_q[rd_addr_q];
  assign row_ok = valid_q[rd_addr_q];

  always_comb begin
    acc_ext = '0;
    acc_ext[VALUE_BITS-1:0] = t_q;
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    t_d         = t_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    rd_addr_d   = rd_addr_q;
    pivot_d     = pivot_q;
    issue_d     = issue_q;
    rd_pend_d   = 1'b0;
    piv_found_d = piv_found_q;
    valid_d     = valid_q;
    rank_d      = rank_q;
    zero_d      = zero_q;
    miss_d      = miss_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = cnt_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = rd_addr_q;
    mem_wdata_o = mem_rdata_i ^ t_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          kind_d      = item_i.kind;
          miss_d      = 1'b0;
          piv_found_d = 1'b0;
          case (item_i.kind)
            KIND_INSERT: begin
              t_d     = item_i.insert_value[VALUE_BITS-1:0];
              cnt_d   = LAST_ROW;
              issue_d = 1'b1;
              state_d = ST_SCAN;
            end
            KIND_QUERY: begin
              t_d = '0;
              if (zero_q && (item_i.query_rank == '0)) begin
                miss_d  = 1'b1;
                state_d = ST_DONE;
              end else if (k_adj == '0) begin
                state_d = ST_DONE;
              end else if ((k_adj & hi_mask) != '0) begin
                miss_d  = 1'b1;
                state_d = ST_DONE;
              end else begin
                k_d     = k_adj[VALUE_BITS-1:0];
                cnt_d   = '0;
                issue_d = 1'b1;
                state_d = ST_QUERY;
              end
            end
            KIND_CLEAR: begin
              valid_d = '0;
              rank_d  = '0;
              zero_d  = 1'b0;
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // high to low; reads are issued ahead, the data meets the updated value
      ST_SCAN: begin
        if (issue_q) begin
          mem_re_o  = 1'b1;
          rd_pend_d = 1'b1;
          rd_addr_d = cnt_q;
          if (cnt_q == '0) begin
            issue_d = 1'b0;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        if (rd_pend_q) begin
          if (rd_bit) begin
            if (row_ok) begin
              t_d = t_q ^ mem_rdata_i;
            end else if (!piv_found_q) begin
              piv_found_d = 1'b1;
              pivot_d     = rd_addr_q;
            end
          end
          if (rd_addr_q == '0) begin
            if (piv_found_d) begin
              if (pivot_d == LAST_ROW) begin
                state_d = ST_PUT;
              end else begin
                cnt_d   = pivot_d + 1'b1;
                issue_d = 1'b1;
                state_d = ST_ELIM;
              end
            end else begin
              zero_d  = 1'b1;
              state_d = ST_DONE;
            end
          end
        end
      end

      // clear the new pivot bit out of every higher row
      ST_ELIM: begin
        if (issue_q) begin
          mem_re_o  = 1'b1;
          rd_pend_d = 1'b1;
          rd_addr_d = cnt_q;
          if (cnt_q == LAST_ROW) begin
            issue_d = 1'b0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (rd_pend_q) begin
          if (row_ok && mem_rdata_i[pivot_q]) begin
            mem_we_o = 1'b1;
          end
          if (rd_addr_q == LAST_ROW) begin
            state_d = ST_PUT;
          end
        end
      end

      ST_PUT: begin
        mem_we_o          = 1'b1;
        mem_waddr_o       = pivot_q;
        mem_wdata_o       = t_q;
        valid_d[pivot_q]  = 1'b1;
        rank_d            = rank_q + 1'b1;
        state_d           = ST_DONE;
      end

      // ascending pivots, each live row eats one bit of k
      ST_QUERY: begin
        if (issue_q) begin
          mem_re_o  = 1'b1;
          rd_pend_d = 1'b1;
          rd_addr_d = cnt_q;
          if (cnt_q == LAST_ROW) begin
            issue_d = 1'b0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (rd_pend_q) begin
          if (row_ok) begin
            if (k_q[0]) begin
              t_d = t_q ^ mem_rdata_i;
            end
            k_d = k_q >> 1;
          end
          if (rd_addr_q == LAST_ROW) begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= 1'b0;
      rd_pend_q   <= 1'b0;
      piv_found_q <= 1'b0;
      valid_q     <= '0;
      rank_q      <= '0;
      zero_q      <= 1'b0;
      miss_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      rd_pend_q   <= rd_pend_d;
      piv_found_q <= piv_found_d;
      valid_q     <= valid_d;
      rank_q      <= rank_d;
      zero_q      <= zero_d;
      miss_q      <= miss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    t_q       <= t_d;
    k_q       <= k_d;
    cnt_q     <= cnt_d;
    rd_addr_q <= rd_addr_d;
    pivot_q   <= pivot_d;
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    res_o.result_value = (kind_q == KIND_QUERY) ? acc_ext : '0;
    res_o.no_such_rank = miss_q;
    res_o.basis_rank   = rank_q;
  end

  `XBK_ASSERT_IMPLY(a_rank_matches_rows, clk_i, rst_ni, 1'b1,
                    $countones(valid_q) == int'(rank_q), "rank differs from live row count")
  `XBK_ASSERT_IMPLY(a_no_rw_same_row, clk_i, rst_ni, mem_we_o && mem_re_o,
                    mem_waddr_o != mem_raddr_o, "row read and written in one cycle")
  `XBK_ASSERT_IMPLY(a_pivot_row_free, clk_i, rst_ni, state_q == ST_PUT,
                    !valid_q[pivot_q], "new pivot lands on a live row")
  `XBK_ASSERT_NEXT(a_result_held, clk_i, rst_ni, (state_q == ST_DONE) && !res_take_i,
                   state_q == ST_DONE, "pending result dropped")
  `XBK_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni,
                   start_i && (state_q == ST_IDLE) && (item_i.kind == KIND_CLEAR),
                   (rank_q == '0) && (valid_q == '0) && !zero_q, "clear left basis state")

endmodule

`default_nettype wire

FILE: hdl/xor_basis_kth_smallest_unit.sv
// ----------------------------------------------------------------------------
// xor_basis_kth_smallest_unit
// fully reduced xor basis with insert, k-th smallest subset xor and clear
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   in_item_i   (xbk_in_t)
// out      output     out_valid_o / out_stall_i out_item_o  (xbk_out_t)
//
// insert: walks every row, plus an elimination pass over the rows above a new pivot
// query: walks every row unless answered from rank alone; clear: no row walk
// the row memory's single read port walks one row per cycle
// reset empties the basis at once through per-row valid bits, no clearing pass
// a stalled output holds its result; the next transaction is taken meanwhile and
// waits for the output register only at its end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xor_basis_kth_smallest_unit #(
  parameter int unsigned VALUE_BITS = xbk_pkg::XBK_VALUE_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  xbk_pkg::xbk_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output xbk_pkg::xbk_out_t out_item_o
);

  import xbk_pkg::*;

  localparam int unsigned AW = $clog2(VALUE_BITS);

  logic seq_idle;
  logic res_valid;
  logic res_take;
  xbk_out_t res;

  logic mem_re;
  logic mem_we;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic [VALUE_BITS-1:0] mem_rdata;
  logic [VALUE_BITS-1:0] mem_wdata;

  logic out_valid_q, out_valid_d;
  xbk_out_t out_item_q;

  xbk_row_ram #(
    .DEPTH(VALUE_BITS),
    .WIDTH(VALUE_BITS)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  xbk_seq #(
    .VALUE_BITS(VALUE_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i && seq_idle),
    .item_i     (in_item_i),
    .idle_o     (seq_idle),
    .res_valid_o(res_valid),
    .res_take_i (res_take),
    .res_o      (res),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata)
  );

  assign in_stall_o = !seq_idle;

  // output register frees the sequencer once the result moves over
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

FILE: tb/tb_xor_basis_kth_smallest_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xor_basis_kth_smallest_unit
// self-checking bench for the xor basis unit: a directed table followed by
// random insert/query/clear/other-kind traffic, random idling on both channels,
// every result checked in order against the table or a built-in basis model
// ----------------------------------------------------------------------------
module tb_xor_basis_kth_smallest_unit;
  import xbk_pkg::*;

  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam logic [62:0] ALL_ONES    = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] TOP_BIT     = 63'h4000_0000_0000_0000;
  localparam int          N_DIRECTED  = 25;
  localparam int          N_RANDOM    = 1725;
  localparam int          QUIET_TAIL  = 150;
  localparam int          HOLD_CYCLES = 500;

  typedef struct {
    xbk_in_t  item;
    bit       typed;
    xbk_out_t want;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  xbk_in_t  in_item_i;
  logic     out_valid_o;
  logic     out_stall_i;
  xbk_out_t out_item_o;

  // shadow basis
  logic [62:0] basis_row [63] = '{default: '0};
  int          basis_rank_m;
  bit          zero_seen;

  xbk_out_t    pending_results [$];
  dir_row_t    directed [N_DIRECTED];
  int          error_count;
  int          checked_count;
  int          idle_pct;
  bit          hold_req;
  bit          fill_mode;
  int          n_insert, n_query, n_miss, n_clear, n_other, top_rank;

  xor_basis_kth_smallest_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_400_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void basis_insert(input logic [62:0] value);
    logic [62:0] t;
    t = value;
    for (int j = 62; j >= 0; j--) begin
      if (t[j]) begin
        if (basis_row[j] != '0) begin
          t ^= basis_row[j];
        end else begin
          // new pivot: reduce against lower rows, then clear it from higher ones
          for (int m = 0; m < j; m++)
            if (t[m]) t ^= basis_row[m];
          for (int m = j + 1; m < 63; m++)
            if (basis_row[m][j]) basis_row[m] ^= t;
          basis_row[j] = t;
          basis_rank_m++;
          return;
        end
      end
    end
    zero_seen = 1'b1;
  endfunction

  function automatic xbk_out_t basis_query(input logic [62:0] rank_k);
    xbk_out_t        res;
    longint unsigned k;
    int unsigned     idx;
    res = '0;
    k   = 64'(rank_k);
    idx = 0;
    if (zero_seen) begin
      if (k == 0) begin
        res.no_such_rank = 1'b1;
        return res;
      end
      k--;
    end
    if (k == 0) return res;
    if (k >= (64'd1 << basis_rank_m)) begin
      res.no_such_rank = 1'b1;
      return res;
    end
    for (int i = 0; i < 63; i++) begin
      if (basis_row[i] != '0) begin
        if (k[idx]) res.result_value ^= basis_row[i];
        idx++;
      end
    end
    return res;
  endfunction

  function automatic xbk_out_t basis_apply(input xbk_in_t it);
    xbk_out_t res;
    res = '0;
    case (it.kind)
      KIND_INSERT: begin
        basis_insert(it.insert_value);
        n_insert++;
      end
      KIND_QUERY: begin
        res = basis_query(it.query_rank);
        n_query++;
        if (res.no_such_rank) n_miss++;
      end
      KIND_CLEAR: begin
        basis_row    = '{default: '0};
        basis_rank_m = 0;
        zero_seen    = 1'b0;
        n_clear++;
      end
      default: n_other++;
    endcase
    res.basis_rank = 6'(basis_rank_m);
    if (basis_rank_m > top_rank) top_rank = basis_rank_m;
    return res;
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] kind, input logic [62:0] iv,
                                      input logic [62:0] qr, input bit typed,
                                      input logic [62:0] res, input bit miss,
                                      input int rank);
    dir_row_t r;
    r.item  = '{kind: kind, insert_value: iv, query_rank: qr};
    r.typed = typed;
    r.want  = '{result_value: res, no_such_rank: miss, basis_rank: 6'(rank)};
    return r;
  endfunction

  function automatic logic [62:0] rand63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[62:0];
  endfunction

  function automatic xbk_in_t random_item();
    xbk_in_t         it;
    int              r;
    int              w;
    longint unsigned span;
    logic [63:0]     k;
    it.kind         = KIND_QUERY;
    it.insert_value = rand63();
    it.query_rank   = rand63();
    r = $urandom_range(99);
    if ((!fill_mode && r < 2) || (fill_mode && basis_rank_m == 63 && r < 1)) begin
      it.kind   = KIND_CLEAR;
      fill_mode = ($urandom_range(9) < 3);
    end else if (r < 5) begin
      it.kind = KIND_UNUSED;
    end else if (r < 52) begin
      it.kind = KIND_INSERT;
      r = $urandom_range(99);
      if (r < 10 && !fill_mode) begin
        it.insert_value = '0;
      end else if (r < 35 || (fill_mode && r < 45)) begin
        // dependent value from the current span
        it.insert_value = '0;
        for (int i = 0; i < 63; i++)
          if ($urandom_range(1)) it.insert_value ^= basis_row[i];
      end else if (r < 60 && !fill_mode) begin
        it.insert_value = '0;
        it.insert_value[$urandom_range(62)] = 1'b1;
        it.insert_value[$urandom_range(62)] = 1'b1;
      end else if (!fill_mode) begin
        w = $urandom_range(63, 1);
        it.insert_value &= ALL_ONES >> (63 - w);
      end
    end else begin
      span = 64'd1 << basis_rank_m;
      r    = $urandom_range(99);
      if (r < 10)      k = '0;
      else if (r < 20) k = 64'd1;
      else if (r < 40) k = span - 1 + 64'(zero_seen);
      else if (r < 50) k = span + 64'(zero_seen);
      else if (r < 85) k = {$urandom, $urandom} % (span + 2);
      else             k = {1'b0, rand63()};
      it.query_rank = k[62:0];
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [62:0] got,
                                 input logic [62:0] want);
    if (error_count < 40)
      $display("tb: result %0d %s: got %0h, expected %0h", checked_count, what, got, want);
    error_count++;
  endtask

  task automatic check_result(input xbk_out_t got);
    xbk_out_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("with no transaction outstanding", got.result_value, '0);
    end else begin
      want = pending_results.pop_front();
      if (got.result_value !== want.result_value)
        report_mismatch("result_value", got.result_value, want.result_value);
      if (got.no_such_rank !== want.no_such_rank)
        report_mismatch("no_such_rank", 63'(got.no_such_rank), 63'(want.no_such_rank));
      if (got.basis_rank !== want.basis_rank)
        report_mismatch("basis_rank", 63'(got.basis_rank), 63'(want.basis_rank));
    end
    checked_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_item_o);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : out_stall_drive
    int burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        burst    = HOLD_CYCLES;
      end else if (burst == 0 && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        burst = $urandom_range(19, 1);
      end
      if (burst != 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic pause_input(input int cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic send_item(input xbk_in_t it, input bit typed, input xbk_out_t want);
    xbk_out_t model;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    model = basis_apply(it);
    pending_results.push_back(typed ? want : model);
  endtask

  initial begin : stimulus
    xbk_in_t  it;
    xbk_out_t none;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    idle_pct    = 0;
    hold_req    = 1'b0;
    fill_mode   = 1'b1;
    none        = '0;

    directed[0]  = mk_row(KIND_QUERY,  '0,       '0,       1, '0, 0, 0);
    directed[1]  = mk_row(KIND_QUERY,  '0,       63'd1,    1, '0, 1, 0);
    directed[2]  = mk_row(KIND_QUERY,  '0,       ALL_ONES, 1, '0, 1, 0);
    directed[3]  = mk_row(KIND_UNUSED, ALL_ONES, ALL_ONES, 1, '0, 0, 0);
    directed[4]  = mk_row(KIND_INSERT, ALL_ONES, '0,       1, '0, 0, 1);
    directed[5]  = mk_row(KIND_INSERT, 63'd1,    '0,       1, '0, 0, 2);
    directed[6]  = mk_row(KIND_QUERY,  '0,       63'd1,    0, '0, 0, 0);
    directed[7]  = mk_row(KIND_QUERY,  '0,       63'd3,    0, '0, 0, 0);
    directed[8]  = mk_row(KIND_QUERY,  '0,       63'd4,    1, '0, 1, 2);
    // zero insert: rank 0 then has no result and rank 1 gives zero
    directed[9]  = mk_row(KIND_INSERT, '0,       '0,       1, '0, 0, 2);
    directed[10] = mk_row(KIND_QUERY,  '0,       '0,       1, '0, 1, 2);
    directed[11] = mk_row(KIND_QUERY,  '0,       63'd1,    1, '0, 0, 2);
    directed[12] = mk_row(KIND_INSERT, TOP_BIT,  '0,       1, '0, 0, 3);
    directed[13] = mk_row(KIND_INSERT, TOP_BIT | 63'd1, '0, 1, '0, 0, 3);
    directed[14] = mk_row(KIND_QUERY,  '0,       ALL_ONES, 1, '0, 1, 3);
    directed[15] = mk_row(KIND_QUERY,  '0,       63'd5,    0, '0, 0, 0);
    directed[16] = mk_row(KIND_QUERY,  '0,       63'd8,    0, '0, 0, 0);
    directed[17] = mk_row(KIND_INSERT, 63'h1555_5555_5555_5555, '0, 0, '0, 0, 0);
    directed[18] = mk_row(KIND_INSERT, 63'h2AAA_AAAA_AAAA_AAAA, '0, 0, '0, 0, 0);
    directed[19] = mk_row(KIND_QUERY,  '0,       63'd2,    0, '0, 0, 0);
    directed[20] = mk_row(KIND_UNUSED, 63'h1555_5555_5555_5555,
                          63'h2AAA_AAAA_AAAA_AAAA, 0, '0, 0, 0);
    directed[21] = mk_row(KIND_CLEAR,  ALL_ONES, ALL_ONES, 1, '0, 0, 0);
    directed[22] = mk_row(KIND_QUERY,  '0,       63'd1,    1, '0, 1, 0);
    directed[23] = mk_row(KIND_INSERT, TOP_BIT,  '0,       1, '0, 0, 1);
    directed[24] = mk_row(KIND_QUERY,  '0,       63'd1,    1, TOP_BIT, 0, 1);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].want);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 12;
          default: idle_pct = 35;
        endcase
      end
      if (n >= N_RANDOM - QUIET_TAIL) idle_pct = 0;
      // long receiver hold-off so the unit backs up into its input
      if (n == 400) hold_req = 1'b1;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        pause_input($urandom_range(19, 1));
      it = random_item();
      send_item(it, 1'b0, none);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    $display("tb: ran %0d inserts, %0d queries (%0d without a rank), %0d clears, %0d other",
             n_insert, n_query, n_miss, n_clear, n_other);
    $display("tb: highest basis rank %0d, %0d results checked, %0d mismatches",
             top_rank, checked_count, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
